@@ src/gizmo_handle_hit_test_macros.svh @@
// ---------------------------------------------------------------------------
// Gizmo handle hit test - assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef GIZMO_HANDLE_HIT_TEST_MACROS_SVH
`define GIZMO_HANDLE_HIT_TEST_MACROS_SVH

// Same-cycle implication.
`define GHHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GHHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ghht_pkg.sv @@
// ---------------------------------------------------------------------------
// Gizmo handle hit test - package
// Mode and result codes, register indexes and fixed widths.
// ---------------------------------------------------------------------------
package ghht_pkg;

    localparam int SIZE_W    = 14;
    localparam int CFG_IDX_W = 2;
    localparam int SCALE_NUM = 179;

    typedef logic [1:0] action_t;
    typedef logic [1:0] hit_t;

    localparam action_t ACT_TRANSLATE = 2'd0;
    localparam action_t ACT_ROTATE    = 2'd1;
    localparam action_t ACT_SCALE     = 2'd2;
    localparam action_t ACT_NONE      = 2'd3;

    localparam hit_t HIT_NONE = 2'd0;
    localparam hit_t HIT_X    = 2'd1;
    localparam hit_t HIT_Y    = 2'd2;
    localparam hit_t HIT_XY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GIZMO_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE_SIZE = 2'd1;

endpackage

@@ src/ghht_if.sv @@
// ---------------------------------------------------------------------------
// Gizmo handle hit test - channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ghht_req_if
    import ghht_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    action_t                      action;
    logic signed [COORD_BITS-1:0] mouse_x;
    logic signed [COORD_BITS-1:0] mouse_y;
    logic signed [COORD_BITS-1:0] gizmo_x;
    logic signed [COORD_BITS-1:0] gizmo_y;

    modport source (output valid, action, mouse_x, mouse_y, gizmo_x, gizmo_y, input ready);
    modport sink   (input valid, action, mouse_x, mouse_y, gizmo_x, gizmo_y, output ready);
endinterface

interface ghht_rsp_if
    import ghht_pkg::*;
;
    logic valid;
    logic ready;
    hit_t hit_axis;

    modport source (output valid, hit_axis, input ready);
    modport sink   (input valid, hit_axis, output ready);
endinterface

interface ghht_cfg_if
    import ghht_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/gizmo_handle_hit_test.sv @@
// ---------------------------------------------------------------------------
// Gizmo handle hit test - top level
// Four-stage pipeline that reports which gizmo handle lies under the pointer.
// ---------------------------------------------------------------------------
// One request enters per clock unless the result is stalled with every stage
// full. The stages, in order: offsets, band compares and seg clamp, squares,
// final sums and priority select into the output register. Throughput is one
// request per cycle while nothing stalls; the squaring stage needs a
// registered difference in front of it and a registered product behind it.
// Each stage holds a valid bit and advances whenever the stage after it is
// empty or moving, so a stalled result only blocks once every stage is
// full. gizmo_size and handle_size are written through cfg (always ready)
// and must only change while no request is in flight. There are no stored
// tables and no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "gizmo_handle_hit_test_macros.svh"

module gizmo_handle_hit_test
    import ghht_pkg::*;
#(
    parameter int COORD_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    ghht_cfg_if.sink    cfg,
    ghht_req_if.sink    req,
    ghht_rsp_if.source  rsp
);

    // Pointer offset width, padded width for offset-minus-size, square width, sum width.
    localparam int CW   = COORD_BITS + 1;
    localparam int DW   = ((CW > SIZE_W + 1) ? CW : SIZE_W + 1) + 1;
    localparam int MW   = 2 * CW;
    localparam int SUMW = ((MW + 1) > 31) ? (MW + 1) : 31;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [SIZE_W-1:0] gizmo_size_reg;
    logic [SIZE_W-1:0] handle_size_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gizmo_size_reg  <= SIZE_W'(1600);
            handle_size_reg <= SIZE_W'(128);
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_GIZMO_SIZE:  gizmo_size_reg  <= cfg.data;
                REG_HANDLE_SIZE: handle_size_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Box half-width B = 2*H, zero-padded to the padded difference width DW.
    logic signed [DW-1:0] box_w;
    logic signed [DW-1:0] size_w;
    assign box_w  = {{(DW - SIZE_W - 1){1'b0}}, handle_size_reg, 1'b0};
    assign size_w = {{(DW - SIZE_W){1'b0}}, gizmo_size_reg};

    // |d| < b without forming the absolute value
    function automatic logic in_band(logic signed [DW-1:0] d, logic signed [DW-1:0] b);
        return (d < b) && (d > -b);
    endfunction

    // -----------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or the next one moves
    // -----------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4      = !out_valid_reg || rsp.ready;
    assign adv3      = !s3_valid_reg  || adv4;
    assign adv2      = !s2_valid_reg  || adv3;
    assign adv1      = !s1_valid_reg  || adv2;
    assign req.ready = adv1;
    assign rsp.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg  <= req.valid;
            if (adv2) s2_valid_reg  <= s1_valid_reg;
            if (adv3) s3_valid_reg  <= s2_valid_reg;
            if (adv4) out_valid_reg <= s3_valid_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: pointer offset from the gizmo centre, scaled axis length
    // -----------------------------------------------------------------------
    action_t              s1_action_reg;
    logic signed [CW-1:0] s1_dx_reg, s1_dy_reg;
    logic [SIZE_W-1:0]    s1_sc_reg;

    logic signed [CW-1:0] s1_dx_next, s1_dy_next;
    logic [SIZE_W+7:0]    sc_prod;

    assign s1_dx_next = {req.mouse_x[COORD_BITS-1], req.mouse_x}
                      - {req.gizmo_x[COORD_BITS-1], req.gizmo_x};
    assign s1_dy_next = {req.mouse_y[COORD_BITS-1], req.mouse_y}
                      - {req.gizmo_y[COORD_BITS-1], req.gizmo_y};
    // 0.7 as 179/256, rounded down
    assign sc_prod    = (SIZE_W + 8)'(gizmo_size_reg) * (SIZE_W + 8)'(SCALE_NUM);

    always_ff @(posedge clk)
    begin
        if (adv1 && req.valid)
        begin
            s1_action_reg <= req.action;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_sc_reg     <= sc_prod[SIZE_W+7:8];
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: box bands for centre, axis ends and scaled ends; segment
    // clamp error; ring bounds; corner offset
    // -----------------------------------------------------------------------
    action_t              s2_action_reg;
    logic signed [CW-1:0] s2_dx_reg, s2_dy_reg, s2_ex_reg, s2_ey_reg;
    logic [SIZE_W-1:0]    s2_c_reg;
    logic                 s2_bx0_reg, s2_by0_reg, s2_bxs_reg, s2_bys_reg;
    logic                 s2_bxsc_reg, s2_bysc_reg;
    logic [SIZE_W:0]      s2_outer_reg;
    logic [SIZE_W-1:0]    s2_inner_reg;
    logic                 s2_inner_ok_reg;

    logic signed [DW-1:0] dxw, dyw, sc_w, dxs, dys, dxsc, dysc;
    logic signed [CW-1:0] ex_next, ey_next;
    logic [SIZE_W+7:0]    c_prod;

    assign dxw  = {{(DW - CW){s1_dx_reg[CW-1]}}, s1_dx_reg};
    assign dyw  = {{(DW - CW){s1_dy_reg[CW-1]}}, s1_dy_reg};
    assign sc_w = {{(DW - SIZE_W){1'b0}}, s1_sc_reg};
    assign dxs  = dxw - size_w;
    assign dys  = dyw - size_w;
    assign dxsc = dxw - sc_w;
    assign dysc = dyw - sc_w;

    // Clamp to the segment [0, S]: error is the overshoot past either end.
    assign ex_next = s1_dx_reg[CW-1] ? s1_dx_reg : ((dxs > 0) ? dxs[CW-1:0] : '0);
    assign ey_next = s1_dy_reg[CW-1] ? s1_dy_reg : ((dys > 0) ? dys[CW-1:0] : '0);
    assign c_prod  = (SIZE_W + 8)'(s1_sc_reg) * (SIZE_W + 8)'(SCALE_NUM);

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_action_reg   <= s1_action_reg;
            s2_dx_reg       <= s1_dx_reg;
            s2_dy_reg       <= s1_dy_reg;
            s2_ex_reg       <= ex_next;
            s2_ey_reg       <= ey_next;
            s2_c_reg        <= c_prod[SIZE_W+7:8];
            s2_bx0_reg      <= in_band(dxw, box_w);
            s2_by0_reg      <= in_band(dyw, box_w);
            s2_bxs_reg      <= in_band(dxs, box_w);
            s2_bys_reg      <= in_band(dys, box_w);
            s2_bxsc_reg     <= in_band(dxsc, box_w);
            s2_bysc_reg     <= in_band(dysc, box_w);
            s2_outer_reg    <= {1'b0, gizmo_size_reg} + {1'b0, handle_size_reg};
            s2_inner_reg    <= gizmo_size_reg - handle_size_reg;
            s2_inner_ok_reg <= (gizmo_size_reg >= handle_size_reg);
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: squares, corner box bands
    // -----------------------------------------------------------------------
    action_t                s3_action_reg;
    logic                   s3_bx0_reg, s3_by0_reg, s3_bxs_reg, s3_bys_reg;
    logic                   s3_bxsc_reg, s3_bysc_reg, s3_bxc_reg, s3_byc_reg;
    logic [MW-1:0]          s3_dx2_reg, s3_dy2_reg, s3_ex2_reg, s3_ey2_reg;
    logic [2*SIZE_W-1:0]    s3_hh_reg, s3_inner2_reg;
    logic [2*SIZE_W+1:0]    s3_outer2_reg;
    logic                   s3_inner_ok_reg;

    logic signed [DW-1:0]   c_w, dxc, dyc;
    logic signed [MW-1:0]   sq_dx, sq_dy, sq_ex, sq_ey;

    assign c_w   = {{(DW - SIZE_W){1'b0}}, s2_c_reg};
    assign dxc   = {{(DW - CW){s2_dx_reg[CW-1]}}, s2_dx_reg} - c_w;
    assign dyc   = {{(DW - CW){s2_dy_reg[CW-1]}}, s2_dy_reg} - c_w;
    assign sq_dx = MW'(s2_dx_reg) * MW'(s2_dx_reg);
    assign sq_dy = MW'(s2_dy_reg) * MW'(s2_dy_reg);
    assign sq_ex = MW'(s2_ex_reg) * MW'(s2_ex_reg);
    assign sq_ey = MW'(s2_ey_reg) * MW'(s2_ey_reg);

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_action_reg   <= s2_action_reg;
            s3_bx0_reg      <= s2_bx0_reg;
            s3_by0_reg      <= s2_by0_reg;
            s3_bxs_reg      <= s2_bxs_reg;
            s3_bys_reg      <= s2_bys_reg;
            s3_bxsc_reg     <= s2_bxsc_reg;
            s3_bysc_reg     <= s2_bysc_reg;
            s3_bxc_reg      <= in_band(dxc, box_w);
            s3_byc_reg      <= in_band(dyc, box_w);
            s3_dx2_reg      <= $unsigned(sq_dx);
            s3_dy2_reg      <= $unsigned(sq_dy);
            s3_ex2_reg      <= $unsigned(sq_ex);
            s3_ey2_reg      <= $unsigned(sq_ey);
            s3_hh_reg       <= (2 * SIZE_W)'(handle_size_reg) * (2 * SIZE_W)'(handle_size_reg);
            s3_inner2_reg   <= (2 * SIZE_W)'(s2_inner_reg) * (2 * SIZE_W)'(s2_inner_reg);
            s3_outer2_reg   <= (2 * SIZE_W + 2)'(s2_outer_reg)
                             * (2 * SIZE_W + 2)'(s2_outer_reg);
            s3_inner_ok_reg <= s2_inner_ok_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 4: distance sums, compares and priority select
    // -----------------------------------------------------------------------
    hit_t            out_hit_reg;
    hit_t            hit_next;
    logic [SUMW-1:0] d2, segx_d2, segy_d2, hh_w;
    logic            seg_x, seg_y, ring;

    assign d2      = SUMW'(s3_dx2_reg) + SUMW'(s3_dy2_reg);
    assign segx_d2 = SUMW'(s3_ex2_reg) + SUMW'(s3_dy2_reg);
    assign segy_d2 = SUMW'(s3_ey2_reg) + SUMW'(s3_dx2_reg);
    assign hh_w    = SUMW'(s3_hh_reg);
    assign seg_x   = segx_d2 < hh_w;
    assign seg_y   = segy_d2 < hh_w;
    // Ring: inside the outer circle, and outside the inner one when it exists
    assign ring    = (d2 < SUMW'(s3_outer2_reg))
                  && (!s3_inner_ok_reg || (d2 > SUMW'(s3_inner2_reg)));

    always_comb
    begin
        hit_next = HIT_NONE;
        case (s3_action_reg)
            ACT_TRANSLATE:
            begin
                if (s3_bx0_reg && s3_by0_reg)      hit_next = HIT_XY;
                else if (s3_bxs_reg && s3_by0_reg) hit_next = HIT_X;
                else if (s3_bx0_reg && s3_bys_reg) hit_next = HIT_Y;
                else if (seg_x)                    hit_next = HIT_X;
                else if (seg_y)                    hit_next = HIT_Y;
            end
            ACT_ROTATE:
            begin
                if (ring) hit_next = HIT_XY;
            end
            ACT_SCALE:
            begin
                if (s3_bxc_reg && s3_byc_reg)       hit_next = HIT_XY;
                else if (s3_bxsc_reg && s3_by0_reg) hit_next = HIT_X;
                else if (s3_bx0_reg && s3_bysc_reg) hit_next = HIT_Y;
            end
            default: hit_next = HIT_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_valid_reg)
            out_hit_reg <= hit_next;
    end

    assign rsp.hit_axis = out_hit_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `GHHT_ASSERT_NOW(a_ready_when_s1_empty, !s1_valid_reg, req.ready,
        "request refused with stage 1 empty")
    `GHHT_ASSERT_NEXT(a_no_phantom_result, !s3_valid_reg && !out_valid_reg,
        !out_valid_reg, "result appeared with no request in stage 3")
    `GHHT_ASSERT_NEXT(a_none_mode_misses,
        s3_valid_reg && adv4 && (s3_action_reg == ACT_NONE),
        out_hit_reg == HIT_NONE, "no-mode request reported a hit")

endmodule
